>>> sv/gfscl_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gfscl_pkg
// Shared types, register map and helper functions for the GPIO
// function-select / set / clear / level register bank.
// -----------------------------------------------------------------------------
package gfscl_pkg;

  localparam int PIN_COUNT     = 32;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 4;
  localparam int FSEL_WORDS    = 4;
  localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
  localparam int PINS_PER_WORD = 10;
  localparam int CODE_BITS     = 3;
  localparam int FSEL_W        = PINS_PER_WORD * CODE_BITS;

  // Register map (word offsets)
  localparam logic [IDX_W-1:0] FSEL_BASE    = 4'd0;
  localparam logic [IDX_W-1:0] SET_OFFSET   = 4'd7;
  localparam logic [IDX_W-1:0] CLEAR_OFFSET = 4'd10;
  localparam logic [IDX_W-1:0] LEVEL_OFFSET = 4'd13;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Function codes
  localparam logic [CODE_BITS-1:0] CODE_INPUT  = 3'b000;
  localparam logic [CODE_BITS-1:0] CODE_OUTPUT = 3'b001;

  typedef logic [FSEL_WORDS-1:0][FSEL_W-1:0] fsel_arr_t;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pin_drive;
    logic [DATA_W-1:0] pin_enable;
  } out_item_t;

  function automatic logic [DATA_W-1:0] pin_mask_calc();
    logic [DATA_W-1:0] m;
    m = '0;
    for (int p = 0; p < DATA_W; p++) begin
      if (p < PIN_COUNT) m[p] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [DATA_W-1:0] PIN_MASK = pin_mask_calc();

  // Bits of each function-select word that belong to an existing pin
  function automatic fsel_arr_t fsel_mask_calc();
    fsel_arr_t m;
    int        p;
    m = '0;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      for (int k = 0; k < PINS_PER_WORD; k++) begin
        p = w * PINS_PER_WORD + k;
        if (p < DATA_W && p < PIN_COUNT) m[w][k*CODE_BITS +: CODE_BITS] = '1;
      end
    end
    return m;
  endfunction

  localparam fsel_arr_t FSEL_MASK = fsel_mask_calc();

  // One bit per pin whose code selects output
  function automatic logic [DATA_W-1:0] enable_bits(input fsel_arr_t fsel);
    logic [DATA_W-1:0] en;
    int                p;
    en = '0;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      for (int k = 0; k < PINS_PER_WORD; k++) begin
        p = w * PINS_PER_WORD + k;
        if (p < DATA_W) begin
          en[p] = (fsel[w][k*CODE_BITS +: CODE_BITS] == CODE_OUTPUT);
        end
      end
    end
    return en & PIN_MASK;
  endfunction

endpackage

>>> sv/gfscl_regs.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gfscl_regs
// Register state and access decode: updates function select and output
// latch for one transaction and forms its result.
// -----------------------------------------------------------------------------
module gfscl_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  gfscl_pkg::in_item_t  item,
  output gfscl_pkg::out_item_t result
);

  gfscl_pkg::fsel_arr_t                fsel;
  gfscl_pkg::fsel_arr_t                fsel_next;
  logic [gfscl_pkg::DATA_W-1:0]        latch;
  logic [gfscl_pkg::DATA_W-1:0]        latch_next;
  logic [gfscl_pkg::DATA_W-1:0]        rd;
  logic [gfscl_pkg::DATA_W-1:0]        en_cur;
  logic [gfscl_pkg::IDX_W-1:0]         fsel_off;
  logic [gfscl_pkg::FSEL_IDX_W-1:0]    widx;
  logic                                hit_fsel;
  logic                                is_write;

  assign fsel_off = item.reg_index - gfscl_pkg::FSEL_BASE;
  assign hit_fsel = (fsel_off < gfscl_pkg::IDX_W'(gfscl_pkg::FSEL_WORDS));
  assign widx     = fsel_off[gfscl_pkg::FSEL_IDX_W-1:0];
  assign is_write = (item.op == gfscl_pkg::OP_WRITE);
  assign en_cur   = gfscl_pkg::enable_bits(fsel);

  // Decode priority: function select, set, clear, level
  always_comb begin
    fsel_next  = fsel;
    latch_next = latch;
    rd         = '0;
    if (hit_fsel) begin
      if (is_write) begin
        fsel_next[widx] = item.write_data[gfscl_pkg::FSEL_W-1:0]
                          & gfscl_pkg::FSEL_MASK[widx];
      end else begin
        rd = gfscl_pkg::DATA_W'(fsel[widx]);
      end
    end else if (item.reg_index == gfscl_pkg::SET_OFFSET) begin
      if (is_write) latch_next = latch | (item.write_data & gfscl_pkg::PIN_MASK);
    end else if (item.reg_index == gfscl_pkg::CLEAR_OFFSET) begin
      if (is_write) latch_next = latch & ~item.write_data & gfscl_pkg::PIN_MASK;
    end else if (item.reg_index == gfscl_pkg::LEVEL_OFFSET) begin
      if (!is_write) begin
        rd = ((latch & en_cur) | (item.pin_levels & ~en_cur)) & gfscl_pkg::PIN_MASK;
      end
    end
  end

  always_comb begin
    result.read_data  = is_write ? '0 : rd;
    result.pin_drive  = latch_next;
    result.pin_enable = gfscl_pkg::enable_bits(fsel_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsel  <= '0;
      latch <= '0;
    end else if (advance) begin
      fsel  <= fsel_next;
      latch <= latch_next;
    end
  end

endmodule

>>> sv/gpio_fsel_set_clear_level.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gpio_fsel_set_clear_level
// 32-pin GPIO bank with function-select, set, clear and level registers.
// -----------------------------------------------------------------------------
// Each input transaction is one register read or write. It is captured in an
// input register, decoded and applied to the register state as it moves
// into an output register, which holds its result (read data plus the pin
// drive and enable after the access). One transaction is taken every cycle
// as long as results are drained. The single input stage and single output
// register set that rate; a stalled output backs up into the input stage and
// then into in_stall. Reset clears all function codes to input and the latch
// to zero. Reads of set or clear and of unmapped offsets return zero.
// -----------------------------------------------------------------------------
module gpio_fsel_set_clear_level (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gfscl_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gfscl_pkg::out_item_t out_item
);

  logic                 s1_valid;
  gfscl_pkg::in_item_t  s1_item;
  gfscl_pkg::out_item_t result;
  logic                 advance;

  // Move the captured transaction into the output register when it is free
  assign advance  = s1_valid && (!out_valid || !out_stall);
  // Hold the input stage while its transaction cannot move on
  assign in_stall = s1_valid && !advance;

  gfscl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .result  (result)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

>>> sv/gfscl_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gfscl_checker
// Port-level checks for the GPIO register bank, bound to the top level.
// -----------------------------------------------------------------------------
module gfscl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input gfscl_pkg::out_item_t out_item
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows a transaction that was accepted
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching transaction");

  // Input stalls only when the output is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind gpio_fsel_set_clear_level gfscl_checker u_gfscl_checker (.*);
